// File: rtl/core/kwc_pkg.sv
// Shared types and constants for the kernel window convolution block.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package kwc_pkg;

    // Fixed field and register widths
    localparam int ROW_W      = 12;    // row counter and out_row
    localparam int WREG_W     = 11;    // image_width register
    localparam int HREG_W     = 13;    // image_height register
    localparam int CFG_W      = 13;    // config write data, widest register
    localparam int CFG_IDX_W  = 1;     // config register index
    localparam int CIDX_W     = 4;     // coeff_index field
    localparam int SUM_OUT_W  = 28;    // conv_sum field
    localparam int MAX_HEIGHT = 4096;  // largest usable frame height

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Input word modes
    localparam logic MODE_KERNEL = 1'b0;
    localparam logic MODE_PIXEL  = 1'b1;

    // Per-word control flags carried down the pipeline
    typedef struct packed {
        logic emit;   // word produces a result
        logic err;    // frame too small for the kernel
        logic last;   // final pixel of the frame
    } t_ctl;

endpackage

// File: rtl/core/kwc_line_buf.sv
// Line store memory plus the KxK window registers.
// Depends on kwc_pkg (t_ctl, ROW_W).
module kwc_line_buf #(
    parameter int KERNEL_SIZE = 3,
    parameter int MAX_WIDTH   = 1024,
    parameter int PIXEL_BITS  = 8
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_push,
    input  logic [$clog2(MAX_WIDTH)-1:0]                 i_col,
    input  logic [PIXEL_BITS-1:0]                        i_pixel,
    input  kwc_pkg::t_ctl                                i_ctl,
    input  logic [kwc_pkg::ROW_W-1:0]                    i_tag_row,
    input  logic [$clog2(MAX_WIDTH)-1:0]                 i_tag_col,
    output logic                                         o_valid,
    output kwc_pkg::t_ctl                                o_ctl,
    output logic [kwc_pkg::ROW_W-1:0]                    o_tag_row,
    output logic [$clog2(MAX_WIDTH)-1:0]                 o_tag_col,
    output logic [KERNEL_SIZE*KERNEL_SIZE*PIXEL_BITS-1:0] o_window
);

    localparam int K     = KERNEL_SIZE;
    localparam int PB    = PIXEL_BITS;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int LROWS = (K > 1) ? K - 1 : 1;
    localparam int LB_W  = LROWS * PB;

    logic [LB_W-1:0] r_mem [MAX_WIDTH];
    logic [LB_W-1:0] r_rdata;
    logic            r_fwd;
    logic [LB_W-1:0] r_fwd_data;

    logic                    r_s1_valid;
    logic [COL_W-1:0]        r_s1_col;
    logic [PB-1:0]           r_s1_pixel;
    kwc_pkg::t_ctl           r_s1_ctl;
    logic [kwc_pkg::ROW_W-1:0] r_s1_row;
    logic [COL_W-1:0]        r_s1_tcol;

    logic                    r_s2_valid;
    kwc_pkg::t_ctl           r_s2_ctl;
    logic [kwc_pkg::ROW_W-1:0] r_s2_row;
    logic [COL_W-1:0]        r_s2_tcol;
    logic [PB-1:0]           r_win [K][K];

    logic [LB_W-1:0] lb_q;
    logic [LB_W-1:0] wdata;
    logic [PB-1:0]   col [K+1];

    // New column: older rows from the store, current pixel at the bottom.
    always_comb begin
        lb_q = r_fwd ? r_fwd_data : r_rdata;
        for (int i = 0; i < K + 1; i++) begin
            col[i] = '0;
        end
        for (int i = 0; i < K - 1; i++) begin
            col[i] = lb_q[i*PB +: PB];
        end
        col[K-1] = r_s1_pixel;
        for (int i = 0; i < LROWS; i++) begin
            wdata[i*PB +: PB] = col[i+1];
        end
    end

    // Line store: read on accept, write back in the cycle after.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_rdata <= r_mem[i_col];
        end
        if (r_s1_valid) begin
            r_mem[r_s1_col] <= wdata;
        end
    end

    // Same-address read while the write is in flight (width of one).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= i_push && r_s1_valid && (r_s1_col == i_col);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= wdata;
        r_s1_col   <= i_col;
        r_s1_pixel <= i_pixel;
        r_s1_ctl   <= i_ctl;
        r_s1_row   <= i_tag_row;
        r_s1_tcol  <= i_tag_col;
        r_s2_ctl   <= r_s1_ctl;
        r_s2_row   <= r_s1_row;
        r_s2_tcol  <= r_s1_tcol;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            for (int i = 0; i < K; i++) begin
                for (int j = 0; j < K; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            r_s1_valid <= i_push;
            r_s2_valid <= r_s1_valid;
            if (r_s1_valid) begin
                for (int i = 0; i < K; i++) begin
                    for (int j = 0; j < K - 1; j++) begin
                        r_win[i][j] <= r_win[i][j+1];
                    end
                    r_win[i][K-1] <= col[i];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < K; i++) begin
            for (int j = 0; j < K; j++) begin
                o_window[(i*K+j)*PB +: PB] = r_win[i][j];
            end
        end
    end

    assign o_valid   = r_s2_valid;
    assign o_ctl     = r_s2_ctl;
    assign o_tag_row = r_s2_row;
    assign o_tag_col = r_s2_tcol;

    a_fwd_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> $past(r_s1_valid))
        else $error("line store forward without a pending write");

endmodule

// File: rtl/core/kwc_mac.sv
// Multiply the window by the flipped kernel and add through a registered tree.
// Depends on kwc_pkg (t_ctl, ROW_W, SUM_OUT_W).
module kwc_mac #(
    parameter int KERNEL_SIZE = 3,
    parameter int MAX_WIDTH   = 1024,
    parameter int PIXEL_BITS  = 8,
    parameter int COEFF_BITS  = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    input  kwc_pkg::t_ctl                                 i_ctl,
    input  logic [kwc_pkg::ROW_W-1:0]                     i_tag_row,
    input  logic [$clog2(MAX_WIDTH)-1:0]                  i_tag_col,
    input  logic [KERNEL_SIZE*KERNEL_SIZE*PIXEL_BITS-1:0] i_window,
    input  logic [KERNEL_SIZE*KERNEL_SIZE*COEFF_BITS-1:0] i_kernel,
    output logic                                          o_push,
    output logic signed [kwc_pkg::SUM_OUT_W-1:0]          o_sum,
    output logic [kwc_pkg::ROW_W-1:0]                     o_row,
    output logic [$clog2(MAX_WIDTH)-1:0]                  o_col,
    output logic                                          o_last,
    output logic                                          o_err
);

    localparam int K      = KERNEL_SIZE;
    localparam int KK     = K * K;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int PROD_W = COEFF_BITS + PIXEL_BITS + 1;
    localparam int RSUM_W = PROD_W + 3;
    localparam int TOT_W  = PROD_W + 6;

    logic signed [PROD_W-1:0] r_prod [KK];
    logic signed [RSUM_W-1:0] r_rsum [K];
    logic signed [TOT_W-1:0]  r_total;
    logic signed [RSUM_W-1:0] rsum [K];
    logic signed [TOT_W-1:0]  total;

    logic [2:0]                r_valid;
    kwc_pkg::t_ctl             r_ctl [3];
    logic [kwc_pkg::ROW_W-1:0] r_row [3];
    logic [COL_W-1:0]          r_col [3];

    // Products: window[i][j] meets kernel[K-1-i][K-1-j].
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < K; i++) begin
            for (int j = 0; j < K; j++) begin
                r_prod[i*K+j] <=
                    $signed(i_kernel[((K-1-i)*K + (K-1-j))*COEFF_BITS +: COEFF_BITS])
                    * $signed({1'b0, i_window[(i*K+j)*PIXEL_BITS +: PIXEL_BITS]});
            end
        end
    end

    always_comb begin
        for (int i = 0; i < K; i++) begin
            rsum[i] = '0;
            for (int j = 0; j < K; j++) begin
                rsum[i] = rsum[i] + RSUM_W'(r_prod[i*K+j]);
            end
        end
        total = '0;
        for (int i = 0; i < K; i++) begin
            total = total + TOT_W'(r_rsum[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < K; i++) begin
            r_rsum[i] <= rsum[i];
        end
        r_total  <= total;
        r_ctl[0] <= i_ctl;
        r_row[0] <= i_tag_row;
        r_col[0] <= i_tag_col;
        for (int s = 1; s < 3; s++) begin
            r_ctl[s] <= r_ctl[s-1];
            r_row[s] <= r_row[s-1];
            r_col[s] <= r_col[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    assign o_push = r_valid[2] && r_ctl[2].emit;
    assign o_sum  = r_ctl[2].err ? '0 : kwc_pkg::SUM_OUT_W'(r_total);
    assign o_row  = r_row[2];
    assign o_col  = r_col[2];
    assign o_last = r_ctl[2].last;
    assign o_err  = r_ctl[2].err;

endmodule

// File: rtl/core/kwc_out_fifo.sv
// Result queue between the arithmetic pipeline and the output channel.
// Depends on kwc_pkg (ROW_W, SUM_OUT_W).
module kwc_out_fifo #(
    parameter int DEPTH = 8,
    parameter int COL_W = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    input  logic signed [kwc_pkg::SUM_OUT_W-1:0] i_sum,
    input  logic [kwc_pkg::ROW_W-1:0]            i_row,
    input  logic [COL_W-1:0]                     i_col,
    input  logic                                 i_last,
    input  logic                                 i_err,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [kwc_pkg::SUM_OUT_W-1:0] o_sum,
    output logic [kwc_pkg::ROW_W-1:0]            o_row,
    output logic [COL_W-1:0]                     o_col,
    output logic                                 o_last,
    output logic                                 o_err
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ENT_W = kwc_pkg::SUM_OUT_W + kwc_pkg::ROW_W + COL_W + 2;

    logic [ENT_W-1:0] r_ent [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             pop;

    assign pop = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr_ptr] <= {i_sum, i_row, i_col, i_last, i_err};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign {o_sum, o_row, o_col, o_last, o_err} = r_ent[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CNT_W'(DEPTH)) || pop)
        else $error("result queue overflow");

endmodule

// File: rtl/core/kernel_window_convolution.sv
// Top level of the streaming KxK valid-region convolution.
// Depends on kwc_pkg, kwc_line_buf, kwc_mac and kwc_out_fifo.
//
//  channel | valid    | stall    | payload
//  --------+----------+----------+----------------------------------------------
//  in      | i_valid  | o_stall  | i_mode i_coeff_index i_coeff_value i_pixel
//  out     | o_valid  | i_stall  | o_conv_sum o_out_row o_out_col o_last
//          |          |          | o_size_error
//  cfg     | i_cfg_we | (none)   | i_cfg_index i_cfg_data
//
// One word per clock is taken while o_stall is low, kernel loads and pixels alike.
// A result goes through the line store read, window update, multiply, row
// sums and total, then the 8-entry result queue.
// Reset (synchronous, active low) clears kernel, window, counters and the
// queue; the line store holds no reset and needs no clearing pass.
// o_stall rises when 8 results are owed (in flight or queued), so an
// output stall backs up into the input without losing any result.
module kernel_window_convolution #(
    parameter int KERNEL_SIZE = 3,
    parameter int MAX_WIDTH   = 1024,
    parameter int PIXEL_BITS  = 8,
    parameter int COEFF_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [kwc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [kwc_pkg::CFG_W-1:0]            i_cfg_data,
    // input words
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_mode,
    input  logic [kwc_pkg::CIDX_W-1:0]           i_coeff_index,
    input  logic signed [COEFF_BITS-1:0]         i_coeff_value,
    input  logic [PIXEL_BITS-1:0]                i_pixel,
    // result words
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [kwc_pkg::SUM_OUT_W-1:0] o_conv_sum,
    output logic [kwc_pkg::ROW_W-1:0]            o_out_row,
    output logic [$clog2(MAX_WIDTH)-1:0]         o_out_col,
    output logic                                 o_last,
    output logic                                 o_size_error
);

    localparam int K      = KERNEL_SIZE;
    localparam int KK     = K * K;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = kwc_pkg::ROW_W;
    localparam int DEPTH  = 8;
    localparam int PEND_W = $clog2(DEPTH + 1);

    // ---------------- configuration registers ----------------
    logic [kwc_pkg::WREG_W-1:0] r_width;
    logic [kwc_pkg::HREG_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= kwc_pkg::WREG_W'(1024);
            r_height <= kwc_pkg::HREG_W'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                kwc_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[kwc_pkg::WREG_W-1:0];
                kwc_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Last column / last row index after clamping the registers to range.
    logic [COL_W-1:0] w_m1;
    logic [ROW_W-1:0] h_m1;

    always_comb begin
        if (r_width == '0) begin
            w_m1 = '0;
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_m1 = COL_W'(MAX_WIDTH - 1);
        end else begin
            w_m1 = COL_W'(r_width - 1'b1);
        end
        if (r_height == '0) begin
            h_m1 = '0;
        end else if (int'(r_height) > kwc_pkg::MAX_HEIGHT) begin
            h_m1 = ROW_W'(kwc_pkg::MAX_HEIGHT - 1);
        end else begin
            h_m1 = ROW_W'(r_height - 1'b1);
        end
    end

    // ---------------- input accept and raster counters ----------------
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [PEND_W-1:0] r_pend;

    logic acc, acc_pix, acc_ld;
    logic at_col_end, at_row_end;
    kwc_pkg::t_ctl ctl;
    logic [ROW_W-1:0] tag_row;
    logic [COL_W-1:0] tag_col;

    assign o_stall = (r_pend == PEND_W'(DEPTH));
    assign acc     = i_valid && !o_stall;
    assign acc_pix = acc && (i_mode == kwc_pkg::MODE_PIXEL);
    assign acc_ld  = acc && (i_mode == kwc_pkg::MODE_KERNEL);

    assign at_col_end = (r_col >= w_m1);
    assign at_row_end = (r_row >= h_m1);

    always_comb begin
        ctl.err  = (int'(w_m1) < K) || (int'(h_m1) < K);
        ctl.last = at_col_end && at_row_end;
        ctl.emit = ctl.err || ((int'(r_row) >= K - 1) && (int'(r_col) >= K - 1));
        // error results carry a zero position
        tag_row  = ctl.err ? '0 : ROW_W'(r_row - ROW_W'(K - 1));
        tag_col  = ctl.err ? '0 : COL_W'(r_col - COL_W'(K - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (acc_pix) begin
            if (at_col_end) begin
                r_col <= '0;
                r_row <= at_row_end ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Results owed: counted from accept until taken at the output.
    logic pend_inc, pend_dec;
    assign pend_inc = acc_pix && ctl.emit;
    assign pend_dec = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            case ({pend_inc, pend_dec})
                2'b10:   r_pend <= r_pend + 1'b1;
                2'b01:   r_pend <= r_pend - 1'b1;
                default: r_pend <= r_pend;
            endcase
        end
    end

    // ---------------- kernel store ----------------
    // Loads are delayed through r_ld1 and r_ld2 so they land exactly between the
    // multiplies of the pixels before and after them.
    logic                        r_ld1_v, r_ld2_v;
    logic [kwc_pkg::CIDX_W-1:0]  r_ld1_idx, r_ld2_idx;
    logic signed [COEFF_BITS-1:0] r_ld1_val, r_ld2_val;
    logic signed [COEFF_BITS-1:0] r_kern [KK];
    logic [KK*COEFF_BITS-1:0]     kernel_flat;

    always_ff @(posedge i_clk) begin
        r_ld1_idx <= i_coeff_index;
        r_ld1_val <= i_coeff_value;
        r_ld2_idx <= r_ld1_idx;
        r_ld2_val <= r_ld1_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld1_v <= 1'b0;
            r_ld2_v <= 1'b0;
            for (int k = 0; k < KK; k++) begin
                r_kern[k] <= '0;
            end
        end else begin
            r_ld1_v <= acc_ld;
            r_ld2_v <= r_ld1_v;
            // indexes past the last coefficient match no entry
            for (int k = 0; k < KK; k++) begin
                if (r_ld2_v && (int'(r_ld2_idx) == k)) begin
                    r_kern[k] <= r_ld2_val;
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < KK; k++) begin
            kernel_flat[k*COEFF_BITS +: COEFF_BITS] = r_kern[k];
        end
    end

    // ---------------- datapath ----------------
    logic                       win_valid;
    kwc_pkg::t_ctl              win_ctl;
    logic [ROW_W-1:0]           win_row;
    logic [COL_W-1:0]           win_col;
    logic [KK*PIXEL_BITS-1:0]   window;

    logic                                 res_push;
    logic signed [kwc_pkg::SUM_OUT_W-1:0] res_sum;
    logic [ROW_W-1:0]                     res_row;
    logic [COL_W-1:0]                     res_col;
    logic                                 res_last;
    logic                                 res_err;

    kwc_line_buf #(
        .KERNEL_SIZE (KERNEL_SIZE),
        .MAX_WIDTH   (MAX_WIDTH),
        .PIXEL_BITS  (PIXEL_BITS)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (acc_pix),
        .i_col     (r_col),
        .i_pixel   (i_pixel),
        .i_ctl     (ctl),
        .i_tag_row (tag_row),
        .i_tag_col (tag_col),
        .o_valid   (win_valid),
        .o_ctl     (win_ctl),
        .o_tag_row (win_row),
        .o_tag_col (win_col),
        .o_window  (window)
    );

    kwc_mac #(
        .KERNEL_SIZE (KERNEL_SIZE),
        .MAX_WIDTH   (MAX_WIDTH),
        .PIXEL_BITS  (PIXEL_BITS),
        .COEFF_BITS  (COEFF_BITS)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (win_valid),
        .i_ctl     (win_ctl),
        .i_tag_row (win_row),
        .i_tag_col (win_col),
        .i_window  (window),
        .i_kernel  (kernel_flat),
        .o_push    (res_push),
        .o_sum     (res_sum),
        .o_row     (res_row),
        .o_col     (res_col),
        .o_last    (res_last),
        .o_err     (res_err)
    );

    kwc_out_fifo #(
        .DEPTH (DEPTH),
        .COL_W (COL_W)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_sum   (res_sum),
        .i_row   (res_row),
        .i_col   (res_col),
        .i_last  (res_last),
        .i_err   (res_err),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_sum   (o_conv_sum),
        .o_row   (o_out_row),
        .o_col   (o_out_col),
        .o_last  (o_last),
        .o_err   (o_size_error)
    );

    // ---------------- checks ----------------
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PEND_W'(DEPTH))
        else $error("owed result count above queue depth");

    a_out_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pend_dec |-> (r_pend != '0))
        else $error("result delivered that was never owed");

    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_pix && !at_col_end) |=> (r_col == $past(r_col) + 1'b1))
        else $error("column counter did not advance");

endmodule

// File: tb/sv/kwc_conv_checker.sv
// Scoreboard for kernel_window_convolution: watches the config port and both word channels.
// Predicts each result word and compares it with what the block sends.
// Depends on kwc_pkg.
module kwc_conv_checker
    import kwc_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]            i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_mode,
    input  logic [CIDX_W-1:0]           i_coeff_index,
    input  logic signed [15:0]          i_coeff_value,
    input  logic [7:0]                  i_pixel,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic signed [SUM_OUT_W-1:0] i_conv_sum,
    input  logic [ROW_W-1:0]            i_out_row,
    input  logic [9:0]                  i_out_col,
    input  logic                        i_last,
    input  logic                        i_size_error,
    output int                          o_owed,
    output int                          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KSIZE     = 3;
    localparam int TAPS      = KSIZE * KSIZE;
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = 10;

    typedef struct {
        logic signed [SUM_OUT_W-1:0] sum;
        logic [ROW_W-1:0]            row;
        logic [COL_W-1:0]            col;
        logic                        last;
        logic                        err;
    } t_conv_word;

    logic signed [15:0] taps [TAPS];
    logic [7:0]         line_mem [KSIZE-1][MAX_WIDTH];
    logic [7:0]         win [KSIZE][KSIZE];
    logic [WREG_W-1:0]  width_reg;
    logic [HREG_W-1:0]  height_reg;
    int unsigned        row_pos;
    int unsigned        col_pos;
    t_conv_word         owed_results [$];
    int                 fails = 0;

    function automatic int unsigned usable_dim(input int unsigned v, input int unsigned hi);
        return (v == 0) ? 1 : ((v > hi) ? hi : v);
    endfunction

    task automatic clear_model();
        width_reg  = 1024;
        height_reg = 1024;
        row_pos    = 0;
        col_pos    = 0;
        for (int i = 0; i < TAPS; i++) taps[i] = '0;
        for (int i = 0; i < KSIZE; i++)
            for (int j = 0; j < KSIZE; j++) win[i][j] = '0;
        for (int i = 0; i < KSIZE - 1; i++)
            for (int c = 0; c < MAX_WIDTH; c++) line_mem[i][c] = '0;
        owed_results.delete();
    endtask

    // One pixel: shift a new column into the window, then owe a word if it completes one or the frame is too small.
    task automatic predict_window_sum(input logic [7:0] pix);
        int unsigned w;
        int unsigned h;
        logic [7:0]  fresh [KSIZE];
        longint      acc;
        bit          too_small;
        bit          frame_end;
        t_conv_word  res;
        w = usable_dim(width_reg, MAX_WIDTH);
        h = usable_dim(height_reg, MAX_HEIGHT);
        for (int i = 0; i < KSIZE - 1; i++) fresh[i] = line_mem[i][col_pos];
        fresh[KSIZE-1] = pix;
        for (int i = 0; i < KSIZE - 1; i++) line_mem[i][col_pos] = fresh[i+1];
        for (int i = 0; i < KSIZE; i++) begin
            for (int j = 0; j < KSIZE - 1; j++) win[i][j] = win[i][j+1];
            win[i][KSIZE-1] = fresh[i];
        end

        too_small = (w <= KSIZE) || (h <= KSIZE);
        frame_end = (row_pos >= h - 1) && (col_pos >= w - 1);
        if (too_small || (row_pos >= KSIZE - 1 && col_pos >= KSIZE - 1)) begin
            res.last = frame_end;
            res.err  = too_small;
            if (too_small) begin
                res.sum = '0;
                res.row = '0;
                res.col = '0;
            end else begin
                acc = 0;
                // kernel is flipped in both directions against the window
                for (int i = 0; i < KSIZE; i++)
                    for (int j = 0; j < KSIZE; j++)
                        acc += longint'(taps[(KSIZE-1-i)*KSIZE + (KSIZE-1-j)])
                               * longint'(win[i][j]);
                res.sum = acc[SUM_OUT_W-1:0];
                res.row = ROW_W'(row_pos - (KSIZE - 1));
                res.col = COL_W'(col_pos - (KSIZE - 1));
            end
            owed_results.push_back(res);
        end

        if (col_pos >= w - 1) begin
            col_pos = 0;
            row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic check_word();
        t_conv_word want;
        if (owed_results.size() == 0) begin
            fails++;
            $display("%0t: result word expected none, got sum %0d row %0d col %0d",
                     $time, i_conv_sum, i_out_row, i_out_col);
        end else begin
            want = owed_results.pop_front();
            compare_field("conv_sum", want.sum, i_conv_sum);
            compare_field("out_row", want.row, i_out_row);
            compare_field("out_col", want.col, i_out_col);
            compare_field("last", want.last, i_last);
            compare_field("size_error", want.err, i_size_error);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_out_valid && !i_out_stall) check_word();
            if (i_cfg_we) begin
                if (i_cfg_index == REG_IMAGE_WIDTH) width_reg = i_cfg_data[WREG_W-1:0];
                else height_reg = i_cfg_data[HREG_W-1:0];
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_mode == MODE_KERNEL) begin
                    if (i_coeff_index < TAPS) taps[i_coeff_index] = i_coeff_value;
                end else begin
                    predict_window_sum(i_pixel);
                end
            end
        end
        o_owed       <= owed_results.size();
        o_fail_count <= fails;
    end

endmodule

// File: tb/sv/tb_top.sv
// Stimulus and verdict for kernel_window_convolution.
// Depends on kwc_pkg, the block itself and kwc_conv_checker, which does all checking.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import kwc_pkg::*;

    localparam int RANDOM_PIXELS  = 150;
    localparam int DRAIN_CYCLES   = 10;    // kernel loads leave no word
    localparam int TAIL_CYCLES    = 20;
    localparam int HOLD_CYCLES    = 400;   // long output hold-off to back up the input
    localparam int WATCHDOG_LIMIT = 3000;  // longest quiet stretch is the hold-off
    localparam logic signed [15:0] CORNER_TAPS [9] = '{
        16'sh8000, 16'sd32767, 16'sd0, 16'sd1, -16'sd1,
        16'sd256, -16'sd256, 16'sd21845, -16'sd21846
    };

    // traffic profiles for the two channels
    typedef enum {FLOW_FREE, FLOW_SENDER_GAPS, FLOW_RECEIVER_STALLS, FLOW_BOTH} t_flow;
    typedef enum {PIX_RANDOM, PIX_WHITE, PIX_BLACK, PIX_EXTREMES} t_pix_style;
    typedef enum {TAPS_RANDOM, TAPS_MAX, TAPS_MIN, TAPS_SMALL} t_tap_style;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index   = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]            i_cfg_data    = '0;
    logic                        i_valid       = 1'b0;
    logic                        i_mode        = MODE_KERNEL;
    logic [CIDX_W-1:0]           i_coeff_index = '0;
    logic signed [15:0]          i_coeff_value = '0;
    logic [7:0]                  i_pixel       = '0;
    logic                        i_stall       = 1'b0;
    logic                        o_stall;
    logic                        o_valid;
    logic signed [SUM_OUT_W-1:0] o_conv_sum;
    logic [ROW_W-1:0]            o_out_row;
    logic [9:0]                  o_out_col;
    logic                        o_last;
    logic                        o_size_error;

    int owed;
    int fail_count;
    int frame_w       = 1024;  // usable frame size, tracked to know frame lengths
    int frame_h       = 1024;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_asked    = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    kernel_window_convolution dut (.*);

    kwc_conv_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_mode        (i_mode),
        .i_coeff_index (i_coeff_index),
        .i_coeff_value (i_coeff_value),
        .i_pixel       (i_pixel),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_conv_sum    (o_conv_sum),
        .i_out_row     (o_out_row),
        .i_out_col     (o_out_col),
        .i_last        (o_last),
        .i_size_error  (o_size_error),
        .o_owed        (owed),
        .o_fail_count  (fail_count)
    );

    // Result side: random stalls, or a long hold-off when the stimulus asks for one.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            i_stall     <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog: any accepted word or config write counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic int usable_dim(input int v, input int hi);
        return (v == 0) ? 1 : ((v > hi) ? hi : v);
    endfunction

    task automatic set_flow(input t_flow f);
        case (f)
            FLOW_FREE:            begin send_idle_pct = 0;  stall_pct <= 0;  end
            FLOW_SENDER_GAPS:     begin send_idle_pct = 48; stall_pct <= 0;  end
            FLOW_RECEIVER_STALLS: begin send_idle_pct = 0;  stall_pct <= 48; end
            default:              begin send_idle_pct = 7;  stall_pct <= 7;  end
        endcase
    endtask

    // Offer one word, with random idle cycles ahead of it; returns at the accepting edge.
    task automatic send_word(input logic mode, input logic [CIDX_W-1:0] idx,
                             input logic signed [15:0] coef, input logic [7:0] pix);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= mode;
        i_coeff_index <= idx;
        i_coeff_value <= coef;
        i_pixel       <= pix;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic load_tap(input logic [CIDX_W-1:0] idx, input logic signed [15:0] coef);
        send_word(MODE_KERNEL, idx, coef, 8'($urandom));
    endtask

    // coefficient fields carry junk on pixel words, the block must ignore them
    task automatic send_pixel(input logic [7:0] pix);
        send_word(MODE_PIXEL, CIDX_W'($urandom), 16'($urandom), pix);
    endtask

    // Sender pause until every owed word is out and the pipe is empty.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (owed == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Only ever called at a frame boundary or for a shrink, never growing width mid-frame.
    task automatic set_dims(input logic [CFG_W-1:0] raw_w, input logic [CFG_W-1:0] raw_h);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_IMAGE_WIDTH;
        i_cfg_data  <= raw_w;
        @(posedge i_clk);
        i_cfg_index <= REG_IMAGE_HEIGHT;
        i_cfg_data  <= raw_h;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        frame_w = usable_dim(int'(raw_w[WREG_W-1:0]), 1024);
        frame_h = usable_dim(int'(raw_h), MAX_HEIGHT);
    endtask

    task automatic load_kernel(input t_tap_style s);
        int                 order [$];
        logic signed [15:0] v;
        for (int k = 0; k < 9; k++) order.push_back(k);
        if ($urandom_range(1)) order.shuffle();
        foreach (order[k]) begin
            case (s)
                TAPS_MAX:   v = 16'sh7FFF;
                TAPS_MIN:   v = 16'sh8000;
                TAPS_SMALL: v = 16'($urandom_range(1023) - 512);
                default:    v = 16'($urandom);
            endcase
            load_tap(CIDX_W'(order[k]), v);
        end
        // occasional write past the last tap, which must be dropped
        if ($urandom_range(9) == 0) load_tap(CIDX_W'($urandom_range(15, 9)), 16'($urandom));
    endtask

    task automatic run_frame(input t_pix_style s, input int noise_pct);
        logic [7:0] pix;
        for (int n = 0; n < frame_w * frame_h; n++) begin
            if ($urandom_range(99) < noise_pct)
                load_tap(CIDX_W'($urandom_range(15)), 16'($urandom));
            case (s)
                PIX_WHITE:    pix = 8'd255;
                PIX_BLACK:    pix = 8'd0;
                PIX_EXTREMES: pix = $urandom_range(1) ? 8'd255 : 8'd0;
                default:      pix = 8'($urandom);
            endcase
            send_pixel(pix);
        end
    endtask

    initial begin
        int pixels_sent;
        int frame_no;
        int w;
        int h;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: corner coefficients, dropped index, smallest valid frame
        for (int k = 0; k < 9; k++) load_tap(CIDX_W'(k), CORNER_TAPS[k]);
        load_tap(4'd15, 16'sh7ABC);
        set_dims(13'd4, 13'd4);
        for (int k = 0; k < 16; k++)
            send_pixel((k % 3 == 0) ? 8'd255 : ((k % 3 == 1) ? 8'd0 : 8'($urandom)));
        // zero registers act as 1x1: a single pixel is an error word that ends the frame
        set_dims(13'd0, 13'd0);
        send_pixel(8'($urandom));

        // --- shrink both registers in mid-frame: counters already past the bound wrap
        set_flow(FLOW_SENDER_GAPS);
        set_dims(13'd12, 13'd10);
        load_kernel(TAPS_RANDOM);
        repeat (6 * 12 + 8) send_pixel(8'($urandom));
        set_dims(13'd5, 13'd4);
        send_pixel(8'($urandom));
        run_frame(PIX_RANDOM, 0);

        // --- long output hold-off with the sender streaming: input must back up
        set_flow(FLOW_FREE);
        set_dims(13'd8, 13'd8);
        hold_asked <= hold_asked + 1;
        run_frame(PIX_RANDOM, 0);

        // --- widest register value: one row of error words, the last for the pixel at column 1023
        set_flow(FLOW_RECEIVER_STALLS);
        set_dims(13'h1FFF, 13'd1);
        run_frame(PIX_RANDOM, 0);

        // --- largest sums of both signs
        set_flow(FLOW_BOTH);
        set_dims(13'd20, 13'd6);
        load_kernel(TAPS_MAX);
        run_frame(PIX_WHITE, 0);
        set_dims(13'd8, 13'd4);
        load_kernel(TAPS_MIN);
        run_frame(PIX_WHITE, 0);

        // --- tallest register value, cut short by shrinking the height in mid-frame
        set_dims(13'd1, 13'h1FFF);
        repeat (40) send_pixel(8'($urandom));
        set_dims(13'd1, 13'd2);
        send_pixel(8'($urandom));    // row past the new bound: closes the frame
        run_frame(PIX_RANDOM, 0);

        // --- random frames, mostly well-formed, with stray tap writes mid-frame
        pixels_sent = 0;
        frame_no    = 0;
        while (pixels_sent < RANDOM_PIXELS) begin
            set_flow(t_flow'(frame_no % 4));
            if (frame_no == 0 || $urandom_range(2) != 0) begin
                if ($urandom_range(4) == 0) begin
                    if ($urandom_range(1)) begin
                        w = $urandom_range(3);
                        h = $urandom_range(9);
                    end else begin
                        w = $urandom_range(12);
                        h = $urandom_range(3);
                    end
                end else begin
                    w = $urandom_range(20, 4);
                    h = $urandom_range(12, 4);
                end
                // upper data bits are outside the width register and must not matter
                set_dims({2'($urandom), 11'(w)}, 13'(h));
            end
            if ($urandom_range(99) < 30) load_kernel(t_tap_style'($urandom_range(3)));
            run_frame(t_pix_style'($urandom_range(3)), 5);
            pixels_sent += frame_w * frame_h;
            frame_no++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
